@@ src/prq_pkg.sv @@
// Package for the priority ready queue: depth, beat types and codes.
`default_nettype none
package prq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] proc_id;
    logic [7:0] prio;
  } req_t;

  typedef struct packed {
    logic [7:0] out_id;
    logic       out_valid;
    status_t    status;
    logic [4:0] occupancy;
  } rsp_t;

  // one slot of the sorted row
  typedef struct packed {
    logic       valid;
    logic [7:0] id;
    logic [7:0] prio;
  } slot_t;

  // broadcast to every cell in a cycle
  typedef struct packed {
    logic       ins;
    logic       del;
    logic [7:0] new_id;
    logic [7:0] new_prio;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ src/prq_cell.sv @@
// One slot of the sorted queue: compare against the new entry and shift.
`default_nettype none
module prq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire prq_pkg::cell_ctrl_t ctrl,
  input  wire prq_pkg::slot_t     left,
  input  wire logic               left_keep,
  input  wire prq_pkg::slot_t     right,
  output prq_pkg::slot_t          slot,
  output logic                    keep
);

  prq_pkg::slot_t slot_next;

  // keep: this slot stays ahead of the new entry (ties stay ahead)
  assign keep = slot.valid && (slot.prio >= ctrl.new_prio);

  always_comb begin
    slot_next = slot;
    if (ctrl.del) begin
      slot_next = right;
    end else if (ctrl.ins) begin
      if (left_keep && !keep) begin
        slot_next.valid = 1'b1;
        slot_next.id    = ctrl.new_id;
        slot_next.prio  = ctrl.new_prio;
      end else if (!left_keep) begin
        slot_next = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.id   <= slot_next.id;
    slot.prio <= slot_next.prio;
  end

endmodule
`default_nettype wire

@@ src/priority_ready_queue.sv @@
// Top level of the priority ready queue: cell row, fill count, result beat.
// Sorted ready queue of prq_pkg::DEPTH entries. Larger prio leaves first,
// equal prio leaves in arrival order. One command is taken per clock (busy
// stays low); its result beat appears with done exactly one cycle later and
// must be taken then, since the receiver cannot stall. That single-cycle
// figure is set by the row of cells: every cell compares its prio with the
// new one and shifts or loads in the same clock. Enqueue on a full queue and
// dequeue on an empty one leave the queue unchanged and report a status.
`default_nettype none
module priority_ready_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire prq_pkg::req_t req,
  output logic               done,
  output prq_pkg::rsp_t      rsp
);

  localparam int unsigned N = prq_pkg::DEPTH;

  prq_pkg::slot_t      slots [N];
  prq_pkg::slot_t      lefts [N];
  prq_pkg::slot_t      rights[N];
  logic [N-1:0]        keeps;
  logic [N-1:0]        left_keeps;
  prq_pkg::cell_ctrl_t ctrl;

  logic [prq_pkg::CW-1:0] count;
  logic [prq_pkg::CW-1:0] count_next;
  logic [prq_pkg::CW+4:0] count_wide;
  logic                   accept;
  logic                   full;
  logic                   empty;
  prq_pkg::rsp_t          rsp_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == prq_pkg::CW'(N));
  assign empty  = !slots[0].valid;

  assign ctrl.ins      = accept && (req.kind == prq_pkg::KIND_ENQ) && !full;
  assign ctrl.del      = accept && (req.kind == prq_pkg::KIND_DEQ) && !empty;
  assign ctrl.new_id   = req.proc_id;
  assign ctrl.new_prio = req.prio;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i]      = slots[i];
      assign left_keeps[i] = 1'b1;
    end else begin : g_mid
      assign lefts[i]      = slots[i-1];
      assign left_keeps[i] = keeps[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_inner
      assign rights[i] = slots[i+1];
    end

    prq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (lefts[i]),
      .left_keep (left_keeps[i]),
      .right     (rights[i]),
      .slot      (slots[i]),
      .keep      (keeps[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.del) begin
      count_next = count - 1'b1;
    end
  end

  assign count_wide = {5'd0, count_next};

  always_comb begin
    rsp_next.out_id    = '0;
    rsp_next.out_valid = 1'b0;
    rsp_next.status    = prq_pkg::ST_OK;
    rsp_next.occupancy = count_wide[4:0];
    if (req.kind == prq_pkg::KIND_DEQ) begin
      if (empty) begin
        rsp_next.status = prq_pkg::ST_EMPTY;
      end else begin
        rsp_next.out_id    = slots[0].id;
        rsp_next.out_valid = 1'b1;
      end
    end else if (full) begin
      rsp_next.status = prq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result beat missing after command");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result beat without command");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= prq_pkg::CW'(N))
    else $error("fill count beyond depth");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    slots[0].valid == (count != '0))
    else $error("head valid disagrees with fill count");

  a_full_unchanged: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == prq_pkg::KIND_ENQ && full) |=> $stable(count))
    else $error("enqueue on full queue changed the count");
`endif

endmodule
`default_nettype wire
